// ----- design/lcc_pkg.sv -----
// ----------------------------------------------------------------------------
// lcc_pkg: shared types, constants and arithmetic helpers
// Command and result beat layouts, queue depths, divide-by-255 and blend math.
// ----------------------------------------------------------------------------
package lcc_pkg;

	localparam int PIX_DEF   = 32;
	localparam int MAX_EMIT  = 32;
	localparam int CQ_DEPTH  = 2;
	localparam int OQ_DEPTH  = 8;
	localparam int OQ_CNT_W  = $clog2(OQ_DEPTH + 1);
	localparam int CNT_W     = 6;

	localparam logic [7:0] FULL = 8'hFF;

	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_COLOR  = 2'd1;
	localparam logic [1:0] OP_ACTIVE = 2'd2;
	localparam logic [1:0] OP_TICK   = 2'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic [4:0]  idx;
		logic [7:0]  prof;
		logic [23:0] color;
		logic        act;
	} cmd_t;

	typedef struct packed {
		logic [4:0] idx;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} res_t;

	typedef struct packed {
		logic [7:0] max_b;
		logic [7:0] min_b;
		logic [7:0] step;
		logic [5:0] piu;
	} cfg_t;

	// exact x / 255 for any 16-bit x below 65280
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] s;
		s = 17'(x) + 17'(x[15:8]) + 17'd1;
		return s[15:8];
	endfunction

	function automatic logic [7:0] mix8(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] t);
		logic [17:0] p;
		p = 18'(a) * 18'(9'd257 - 9'(t)) + 18'(b) * 18'(t);
		return p[15:8];
	endfunction

	function automatic logic [23:0] mix_pixel(input logic [23:0] a, input logic [23:0] b,
			input logic [7:0] t);
		logic [23:0] r;
		if (t == 8'd0) begin
			r = a;
		end else if (t == FULL) begin
			r = b;
		end else begin
			r = {mix8(a[23:16], b[23:16], t), mix8(a[15:8], b[15:8], t),
				mix8(a[7:0], b[7:0], t)};
		end
		return r;
	endfunction

endpackage

// ----- design/lcc_ram.sv -----
// ----------------------------------------------------------------------------
// lcc_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- design/lcc_fifo.sv -----
// ----------------------------------------------------------------------------
// lcc_fifo: small register FIFO
// Flop-based queue with first-word fall-through output and an occupancy count.
// ----------------------------------------------------------------------------
module lcc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             full,
	output logic             empty,
	output logic [CW-1:0]    count
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             wr_en;
	logic             rd_en;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign count = count_q;
	assign dout  = mem_q[rd_ptr_q];
	assign wr_en = push && !full;
	assign rd_en = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			count_q <= count_q + CW'(wr_en) - CW'(rd_en);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

// ----- design/lcc_front.sv -----
// ----------------------------------------------------------------------------
// lcc_front: command intake
// Accepts input beats, drops out-of-range profile loads, queues the rest.
// ----------------------------------------------------------------------------
module lcc_front #(
	parameter int PIXEL_COUNT = lcc_pkg::PIX_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         cmd,
	input  logic [4:0]         pixel_index,
	input  logic [7:0]         profile_value,
	input  logic [23:0]        color_rgb,
	input  logic               active_flag,
	output logic               cq_valid,
	output lcc_pkg::cmd_t      cq_data,
	input  logic               cq_pop
);
	import lcc_pkg::*;

	cmd_t                   cmd_in;
	logic                   keep;
	logic                   cq_empty;
	logic [$clog2(CQ_DEPTH+1)-1:0] cq_cnt;

	assign cmd_in = '{op: cmd, idx: pixel_index, prof: profile_value,
		color: color_rgb, act: active_flag};
	assign keep = (cmd != OP_LOAD) || (int'(pixel_index) < PIXEL_COUNT);

	lcc_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(CQ_DEPTH)
	) u_cq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push && keep),
		.din   (cmd_in),
		.pop   (cq_pop),
		.dout  (cq_data),
		.full  (full),
		.empty (cq_empty),
		.count (cq_cnt)
	);

	assign cq_valid = !cq_empty && (cq_cnt != '0);

endmodule

// ----- design/lcc_back.sv -----
// ----------------------------------------------------------------------------
// lcc_back: command executor and pixel sweep engine
// Runs queued commands in order; frame ticks in a non-idle mode sweep the pixel
// stores through a three-stage pipeline that builds goal pixels or blends and emits them.
// ----------------------------------------------------------------------------
module lcc_back #(
	parameter int PIXEL_COUNT = lcc_pkg::PIX_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lcc_pkg::cfg_t                cfg,
	input  logic                         cq_valid,
	input  lcc_pkg::cmd_t                cq_data,
	output logic                         cq_pop,
	input  logic [lcc_pkg::OQ_CNT_W-1:0] res_cnt,
	output logic                         res_push,
	output lcc_pkg::res_t                res_data
);
	import lcc_pkg::*;

	localparam int AW   = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
	localparam int NCAP = (PIXEL_COUNT < MAX_EMIT) ? PIXEL_COUNT : MAX_EMIT;

	localparam logic ST_CMD   = 1'b0;
	localparam logic ST_SWEEP = 1'b1;

	localparam logic [1:0] MODE_IDLE     = 2'd0;
	localparam logic [1:0] MODE_SCHED    = 2'd1;
	localparam logic [1:0] MODE_CHANGING = 2'd2;
	localparam logic [1:0] MODE_FINISHED = 2'd3;

	localparam logic KIND_GOAL  = 1'b0;
	localparam logic KIND_BLEND = 1'b1;

	logic                   state_q;
	logic [1:0]             mode_q;
	logic [8:0]             fade_q;
	logic [23:0]            color_q;
	logic                   active_q;
	logic [7:0]             t_q;
	logic                   kind_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [PIXEL_COUNT-1:0] prof_vld_q;
	logic [PIXEL_COUNT-1:0] shown_vld_q;

	logic             v_s1, v_s2, v_s3;
	logic [CNT_W-1:0] idx_s1, idx_s2, idx_s3;
	logic             last_s1, last_s2, last_s3;
	logic             pok_s1, sok_s1;
	logic [23:0]      px_s2, px_s3;
	logic [7:0]       w_s2;
	logic [23:0]      gl_s3;

	logic [CNT_W-1:0] n_px;
	logic [7:0]       tc;
	logic [8:0]       nf;
	logic [OQ_CNT_W:0] occ;
	logic             credit;
	logic             issue;
	logic             sweep_done;
	logic [AW-1:0]    raddr;
	logic [AW-1:0]    cmd_addr;
	logic [AW-1:0]    wb_addr;
	logic [7:0]       bright;
	logic [7:0]       prof_rd;
	logic [23:0]      shown_rd;
	logic [7:0]       prof_ram;
	logic [23:0]      shown_ram;
	logic [23:0]      start_ram;
	logic [23:0]      goal_ram;
	logic             prof_we;
	logic             goal_wb;
	logic             blend_wb;

	assign n_px   = (cfg.piu > CNT_W'(NCAP)) ? CNT_W'(NCAP) : cfg.piu;
	assign tc     = (fade_q > 9'd255) ? FULL : fade_q[7:0];
	assign nf     = {1'b0, tc} + {1'b0, cfg.step};
	assign occ    = {1'b0, res_cnt} + (OQ_CNT_W+1)'(v_s1) + (OQ_CNT_W+1)'(v_s2)
		+ (OQ_CNT_W+1)'(v_s3);
	assign credit = (kind_q == KIND_GOAL) || (occ < (OQ_CNT_W+1)'(OQ_DEPTH));
	assign issue  = (state_q == ST_SWEEP) && (cnt_q < n_px) && credit;
	assign sweep_done = (state_q == ST_SWEEP) && (cnt_q >= n_px) && !v_s1 && !v_s2 && !v_s3;

	assign raddr    = cnt_q[AW-1:0];
	assign cmd_addr = AW'(cq_data.idx);
	assign wb_addr  = idx_s3[AW-1:0];
	assign cq_pop   = (state_q == ST_CMD) && cq_valid;
	assign prof_we  = cq_pop && (cq_data.op == OP_LOAD);
	assign goal_wb  = v_s3 && (kind_q == KIND_GOAL);
	assign blend_wb = v_s3 && (kind_q == KIND_BLEND);

	assign bright   = active_q ? cfg.max_b : cfg.min_b;
	assign prof_rd  = pok_s1 ? prof_ram : FULL;
	assign shown_rd = sok_s1 ? shown_ram : 24'd0;

	lcc_ram #(.WIDTH(8), .DEPTH(PIXEL_COUNT)) u_prof (
		.clk(clk), .we(prof_we), .waddr(cmd_addr), .wdata(cq_data.prof),
		.raddr(raddr), .rdata(prof_ram)
	);

	lcc_ram #(.WIDTH(24), .DEPTH(PIXEL_COUNT)) u_shown (
		.clk(clk), .we(blend_wb), .waddr(wb_addr), .wdata(px_s3),
		.raddr(raddr), .rdata(shown_ram)
	);

	lcc_ram #(.WIDTH(24), .DEPTH(PIXEL_COUNT)) u_start (
		.clk(clk), .we(goal_wb), .waddr(wb_addr), .wdata(px_s3),
		.raddr(raddr), .rdata(start_ram)
	);

	lcc_ram #(.WIDTH(24), .DEPTH(PIXEL_COUNT)) u_goal (
		.clk(clk), .we(goal_wb), .waddr(wb_addr), .wdata(gl_s3),
		.raddr(raddr), .rdata(goal_ram)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CMD;
			mode_q      <= MODE_IDLE;
			fade_q      <= '0;
			color_q     <= '0;
			active_q    <= 1'b0;
			t_q         <= '0;
			kind_q      <= KIND_GOAL;
			cnt_q       <= '0;
			prof_vld_q  <= '0;
			shown_vld_q <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (issue) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (blend_wb) begin
				shown_vld_q[wb_addr] <= 1'b1;
			end
			if (sweep_done) begin
				state_q <= ST_CMD;
			end
			if (cq_pop) begin
				unique case (cq_data.op)
					OP_LOAD: begin
						prof_vld_q[cmd_addr] <= 1'b1;
					end
					OP_COLOR: begin
						color_q <= cq_data.color;
						mode_q  <= MODE_SCHED;
					end
					OP_ACTIVE: begin
						active_q <= cq_data.act;
						mode_q   <= MODE_SCHED;
					end
					OP_TICK: begin
						unique case (mode_q)
							MODE_SCHED: begin
								kind_q  <= KIND_GOAL;
								fade_q  <= '0;
								mode_q  <= MODE_CHANGING;
								state_q <= ST_SWEEP;
								cnt_q   <= '0;
							end
							MODE_CHANGING: begin
								t_q     <= tc;
								fade_q  <= nf;
								if (nf >= 9'd255) begin
									mode_q <= MODE_FINISHED;
								end
								kind_q  <= KIND_BLEND;
								state_q <= ST_SWEEP;
								cnt_q   <= '0;
							end
							MODE_FINISHED: begin
								t_q     <= FULL;
								mode_q  <= MODE_IDLE;
								kind_q  <= KIND_BLEND;
								state_q <= ST_SWEEP;
								cnt_q   <= '0;
							end
							default: begin
							end
						endcase
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= cnt_q;
		last_s1 <= ((cnt_q + CNT_W'(1)) == n_px);
		pok_s1  <= prof_vld_q[raddr];
		sok_s1  <= shown_vld_q[raddr];

		idx_s2  <= idx_s1;
		last_s2 <= last_s1;
		w_s2    <= div255(16'(bright) * 16'(prof_rd));
		px_s2   <= (kind_q == KIND_GOAL) ? shown_rd : mix_pixel(start_ram, goal_ram, t_q);

		idx_s3  <= idx_s2;
		last_s3 <= last_s2;
		px_s3   <= px_s2;
		gl_s3   <= {div255(16'(color_q[23:16]) * 16'(w_s2)),
			div255(16'(color_q[15:8]) * 16'(w_s2)),
			div255(16'(color_q[7:0]) * 16'(w_s2))};
	end

	assign res_push = blend_wb;
	assign res_data = '{idx: idx_s3[4:0], red: px_s3[23:16], green: px_s3[15:8],
		blue: px_s3[7:0], last: last_s3};

	a_mode_only_in_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_CMD) |=> $stable(mode_q))
		else $error("mode changed during a sweep");

	a_pipe_empty_in_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMD) |-> !(v_s1 || v_s2 || v_s3))
		else $error("pipeline busy while taking a command");

	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (res_cnt < OQ_CNT_W'(OQ_DEPTH)))
		else $error("result beat pushed into a full queue");

endmodule

// ----- design/led_strip_crossfade_controller.sv -----
// ----------------------------------------------------------------------------
// led_strip_crossfade_controller: LED strip crossfade engine
// Command queue in front, sweep engine behind, result queue at the output.
// ----------------------------------------------------------------------------
// Usage:
//   Command beats enter on push/full: profile loads, colour and active-flag
//   changes, and frame ticks. Pixel beats leave on empty/pop, oldest first,
//   in index order, last_pixel marking the final pixel of a frame.
//   Registers sit on the APB port at 0x0 max_brightness, 0x4 min_brightness,
//   0x8 fade_step, 0xC pixels_in_use; write them only while the block is idle.
// Flow:
//   Non-tick commands are taken whenever the executor is not sweeping. A tick
//   that builds the goal pixels or emits a frame sweeps pixels_in_use (at most
//   32) pixels through the sweep pipeline (store read, multiply/blend, multiply)
//   at one pixel per cycle, emitting only while the result queue has room, then
//   drains. A frame's first pixel passes the sweep state, these stages and the
//   result queue. A two-entry command queue lets the source run ahead.
// Reset:
//   Registers return to 255/0/16/32, the strip goes idle and dark, and all
//   profile weights read as full.
// Stall:
//   If the receiver stops popping, the eight-entry result queue fills, the
//   sweep pauses, and then the command queue fills and full rises.
// ----------------------------------------------------------------------------
module led_strip_crossfade_controller #(
	parameter int PIXEL_COUNT = lcc_pkg::PIX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  cmd,
	input  logic [4:0]  pixel_index,
	input  logic [7:0]  profile_value,
	input  logic [23:0] color_rgb,
	input  logic        active_flag,
	output logic        empty,
	input  logic        pop,
	output logic [4:0]  out_index,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic        last_pixel,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import lcc_pkg::*;

	localparam logic [1:0] REG_MAX_B = 2'd0;
	localparam logic [1:0] REG_MIN_B = 2'd1;
	localparam logic [1:0] REG_STEP  = 2'd2;
	localparam logic [1:0] REG_PIU   = 2'd3;

	cfg_t              cfg_q;
	logic              cfg_wr;
	logic              cq_valid;
	cmd_t              cq_data;
	logic              cq_pop;
	logic              res_push;
	res_t              res_data;
	res_t              res_out;
	logic              res_full;
	logic [OQ_CNT_W-1:0] res_cnt;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{max_b: 8'd255, min_b: 8'd0, step: 8'd16, piu: 6'd32};
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_MAX_B: cfg_q.max_b <= pwdata[7:0];
				REG_MIN_B: cfg_q.min_b <= pwdata[7:0];
				REG_STEP:  cfg_q.step  <= pwdata[7:0];
				REG_PIU:   cfg_q.piu   <= pwdata[5:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_MAX_B: prdata = {24'd0, cfg_q.max_b};
			REG_MIN_B: prdata = {24'd0, cfg_q.min_b};
			REG_STEP:  prdata = {24'd0, cfg_q.step};
			REG_PIU:   prdata = {26'd0, cfg_q.piu};
			default:   prdata = '0;
		endcase
	end

	lcc_front #(.PIXEL_COUNT(PIXEL_COUNT)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.cmd          (cmd),
		.pixel_index  (pixel_index),
		.profile_value(profile_value),
		.color_rgb    (color_rgb),
		.active_flag  (active_flag),
		.cq_valid     (cq_valid),
		.cq_data      (cq_data),
		.cq_pop       (cq_pop)
	);

	lcc_back #(.PIXEL_COUNT(PIXEL_COUNT)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.cq_valid(cq_valid),
		.cq_data (cq_data),
		.cq_pop  (cq_pop),
		.res_cnt (res_cnt),
		.res_push(res_push),
		.res_data(res_data)
	);

	lcc_fifo #(
		.WIDTH($bits(res_t)),
		.DEPTH(OQ_DEPTH)
	) u_oq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.din   (res_data),
		.pop   (pop),
		.dout  (res_out),
		.full  (res_full),
		.empty (empty),
		.count (res_cnt)
	);

	assign out_index  = res_out.idx;
	assign out_red    = res_out.red;
	assign out_green  = res_out.green;
	assign out_blue   = res_out.blue;
	assign last_pixel = res_out.last && !(res_full && empty);

endmodule
